FILE: hdl/sawa_pkg.sv
// ----------------------------------------------------------------------------
// sawa_pkg
// Types, constants and sizes shared by the stop-and-wait sender modules.
// ----------------------------------------------------------------------------
package sawa_pkg;

	localparam int LINE_BYTES    = 256;
	localparam int PAYLOAD_BYTES = 6;

	localparam int ADDR_W = $clog2(LINE_BYTES);
	localparam int LEN_W  = $clog2(LINE_BYTES + 1);
	localparam int POS_W  = $clog2(LINE_BYTES + PAYLOAD_BYTES);
	localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 2);

	localparam logic [CNT_W-1:0] LAST_ELEM = CNT_W'(PAYLOAD_BYTES + 1);

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_A    = 8'h61;
	localparam logic [7:0] CHAR_C    = 8'h63;
	localparam logic [7:0] CHAR_K    = 8'h6B;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] line_byte;
		logic       line_end;
		logic [7:0] ack_first;
		logic [7:0] ack_second;
		logic [7:0] ack_third;
		logic [7:0] ack_seq_char;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] frame_byte;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic             report;
		logic [POS_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             seq;
	} frame_req_t;

endpackage

FILE: hdl/sawa_line_mem.sv
// ----------------------------------------------------------------------------
// sawa_line_mem
// Line buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sawa_line_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sawa_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [sawa_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);
	import sawa_pkg::*;

	logic [7:0] mem [LINE_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/sawa_frame_gen.sv
// ----------------------------------------------------------------------------
// sawa_frame_gen
// Walks one frame or one done report out, one result per cycle unless the full
// output register is not taken, reading the payload from the line buffer.
// ----------------------------------------------------------------------------
module sawa_frame_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sawa_pkg::frame_req_t        req,
	input  logic [7:0]                  rd_data,
	output logic [sawa_pkg::ADDR_W-1:0] rd_addr,
	output logic                        busy,
	output logic                        result_valid,
	input  logic                        result_ready,
	output sawa_pkg::result_t           result
);
	import sawa_pkg::*;

	logic             active_q;
	logic             report_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] off_q;
	logic [LEN_W-1:0] len_q;
	logic             seq_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             advance;
	logic [CNT_W-1:0] sel_elem;
	logic [POS_W-1:0] rd_pos;
	logic [POS_W-1:0] cur_pos;
	logic             in_text;
	result_t          elem;

	assign advance  = active_q && (!out_valid_q || result_ready);
	assign sel_elem = advance ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign rd_pos   = off_q + POS_W'(sel_elem) - POS_W'(1);
	assign rd_addr  = rd_pos[ADDR_W-1:0];
	assign cur_pos  = off_q + POS_W'(cnt_q) - POS_W'(1);
	assign in_text  = cur_pos < POS_W'(len_q);

	always_comb begin
		elem.kind       = KIND_FRAME;
		elem.frame_byte = 8'd0;
		elem.run_last   = 1'b0;
		priority if (report_q) begin
			elem.kind     = KIND_DONE;
			elem.run_last = 1'b1;
		end else if (cnt_q == '0) begin
			elem.frame_byte = CHAR_ZERO | {7'd0, seq_q};
		end else if (cnt_q == LAST_ELEM) begin
			elem.run_last = 1'b1;
		end else if (in_text) begin
			elem.frame_byte = rd_data;
		end else begin
			elem.frame_byte = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid) begin
				active_q <= 1'b1;
			end else if (advance && (report_q || cnt_q == LAST_ELEM)) begin
				active_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			report_q <= req.report;
			cnt_q    <= '0;
			off_q    <= req.off;
			len_q    <= req.len;
			seq_q    <= req.seq;
		end else if (advance) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (advance) begin
			out_q <= elem;
		end
	end

	assign busy         = active_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !active_q)
		else $error("frame request while a run is still in progress");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= LAST_ELEM))
		else $error("frame element counter out of range");

	a_report_single: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && report_q) |-> (cnt_q == '0))
		else $error("done report ran past one result");

endmodule

FILE: hdl/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Alternating-bit stop-and-wait sender with an on-chip line buffer.
// ----------------------------------------------------------------------------
// Line bytes are taken one per cycle, back to back, and written into the line
// buffer. The transaction that carries the end of line starts a frame of
// PAYLOAD_BYTES + 2 results (8 by default), which the frame generator emits one
// byte per cycle while the output is taken, through the single read port of the
// line buffer. A transaction that starts a frame or a done report holds off the
// next input transaction while that run is in progress, and a full output
// register that is not taken lengthens the hold-off. A new input transaction is
// taken as soon as the generator has moved the last result of the previous run
// into the output register.
module stop_and_wait_arq_sender (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sawa_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output sawa_pkg::result_t result
);
	import sawa_pkg::*;

	logic [LEN_W-1:0] len_q, len_d;
	logic [POS_W-1:0] off_q, off_d;
	logic             seq_q, seq_d;
	logic             sending_q, sending_d;
	logic             ended_q, ended_d;

	logic             accept;
	logic             busy;
	logic             match;
	logic [POS_W-1:0] off_sum;
	logic             we;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	frame_req_t       req;

	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;
	assign match      = item.ack_first == CHAR_A && item.ack_second == CHAR_C
		&& item.ack_third == CHAR_K && item.ack_seq_char == (CHAR_ZERO | {7'd0, seq_q});
	assign off_sum    = off_q + POS_W'(PAYLOAD_BYTES);

	always_comb begin
		len_d     = len_q;
		off_d     = off_q;
		seq_d     = seq_q;
		sending_d = sending_q;
		ended_d   = ended_q;
		we        = 1'b0;
		req       = '0;
		if (accept) begin
			unique case (item.cmd)
				CMD_LOAD: begin
					if (!sending_q) begin
						if (!ended_q) begin
							if (item.line_byte == 8'd0) begin
								ended_d = 1'b1;
							end else if (len_q < LEN_W'(LINE_BYTES)) begin
								we    = 1'b1;
								len_d = len_q + LEN_W'(1);
							end
						end
						if (item.line_end) begin
							sending_d = 1'b1;
							off_d     = '0;
							req.valid = 1'b1;
							req.off   = '0;
							req.len   = len_d;
							req.seq   = seq_q;
						end
					end
				end
				CMD_ACK, CMD_TIMEOUT: begin
					if (sending_q) begin
						req.valid = 1'b1;
						req.off   = off_q;
						req.len   = len_q;
						req.seq   = seq_q;
						if (item.cmd == CMD_ACK && match) begin
							seq_d = !seq_q;
							if (off_sum >= POS_W'(len_q)) begin
								sending_d  = 1'b0;
								len_d      = '0;
								off_d      = '0;
								ended_d    = 1'b0;
								req.report = 1'b1;
							end else begin
								off_d   = off_sum;
								req.off = off_sum;
								req.seq = !seq_q;
							end
						end
					end
				end
				CMD_UNUSED: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			off_q     <= '0;
			seq_q     <= 1'b0;
			sending_q <= 1'b0;
			ended_q   <= 1'b0;
		end else begin
			len_q     <= len_d;
			off_q     <= off_d;
			seq_q     <= seq_d;
			sending_q <= sending_d;
			ended_q   <= ended_d;
		end
	end

	sawa_line_mem u_line_mem (
		.clk   (clk),
		.we    (we),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (item.line_byte),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sawa_frame_gen u_frame_gen (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rd_data      (rd_data),
		.rd_addr      (rd_addr),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_idle_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (off_q == '0))
		else $error("send offset nonzero while no line is being sent");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_BYTES))
		else $error("line length beyond buffer size");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.report) |=> (len_q == '0 && !sending_q && !ended_q))
		else $error("line state not cleared after the done report");

endmodule
